/* rtl/rbwd_pkg.sv */
package rbwd_pkg;

    localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [15:0] NULL_TOTAL_MAX = 16'hFFFF;
    localparam logic [15:0] WIDE_LIMIT     = 16'd192;
    localparam logic [7:0]  UNIT_ALIAS     = 8'd13;
    localparam logic [7:0]  UNIT_A         = 8'd5;
    localparam logic [7:0]  UNIT_B         = 8'd11;
    localparam logic [7:0]  TYPE_EMPTY     = 8'd1;
    localparam logic [7:0]  TYPE_SKIP      = 8'd2;
    localparam logic [7:0]  SAMPLES_RESET  = 8'd4;

    typedef enum logic [3:0] {
        PH_HDR   = 4'd0,
        PH_SCA   = 4'd1,
        PH_CNT1  = 4'd2,
        PH_CNT2  = 4'd3,
        PH_LOC   = 4'd4,
        PH_TW    = 4'd5,
        PH_SAMP  = 4'd6,
        PH_GHOST = 4'd7,
        PH_SKIP  = 4'd8
    } phase_t;

    typedef enum logic [3:0] {
        WC_HEADER    = 4'd0,
        WC_SAMP_ADDR = 4'd1,
        WC_COUNTS    = 4'd2,
        WC_COUNT2    = 4'd3,
        WC_LOCATION  = 4'd4,
        WC_TIME_W    = 4'd5,
        WC_SAMPLE    = 4'd6,
        WC_GHOST     = 4'd7,
        WC_ERR_SKIP  = 4'd8,
        WC_IDLE      = 4'd9
    } word_class_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_OVERRUN = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic        fragment_start;
    } item_t;

    typedef struct packed {
        word_class_t word_class;
        logic [7:0]  unit_id;
        logic [7:0]  block_type;
        logic [31:0] raw_word;
        logic [11:0] cluster_time;
        logic [15:0] cluster_width;
        logic        time_is_computed;
        logic [15:0] sample_word_count;
        logic        block_end;
        status_t     status;
        logic        width_unrealistic;
        logic [15:0] missing_block_count;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [16:0] words_counted;
        logic [15:0] block_size;
        logic [10:0] clusters_left;
        logic [15:0] samples_left;
        logic [7:0]  current_unit;
        logic [7:0]  current_type;
        logic        wide_cluster_seen;
        logic [15:0] null_header_total;
    } state_t;

endpackage

/* rtl/rbwd_decode.sv */
module rbwd_decode
    import rbwd_pkg::*;
(
    input  item_t       item,
    input  state_t      state_cur,
    input  logic [7:0]  samples_per_channel,
    output state_t      state_next,
    output result_t     result
);

    typedef struct packed {
        phase_t      phase;
        logic [10:0] clusters;
        status_t     status;
        logic        end_flag;
    } fin_t;

    // Close one cluster: pick the next cluster, ghost words or block end
    function automatic fin_t finish_cluster(
        input logic [10:0] cl,
        input logic [16:0] wc,
        input logic [15:0] bs
    );
        fin_t        f;
        logic [10:0] left;
        left       = (cl != 11'd0) ? cl - 11'd1 : cl;
        f.clusters = left;
        f.status   = ST_OK;
        f.end_flag = 1'b0;
        f.phase    = PH_HDR;
        if (left != 11'd0) begin
            f.phase = PH_LOC;
        end else if (wc > {1'b0, bs}) begin
            f.end_flag = 1'b1;
            f.status   = ST_OVERRUN;
        end else if (wc < {1'b0, bs}) begin
            f.phase = PH_GHOST;
        end else begin
            f.end_flag = 1'b1;
        end
        return f;
    endfunction

    logic [31:0] d;
    logic [7:0]  unit_fix;
    logic [16:0] wc_bump;
    logic [9:0]  cnt1_sum;
    logic [10:0] cnt2_sum;
    logic [23:0] prod;
    logic [22:0] half_up;
    logic [15:0] swc;
    logic [15:0] samp_dec;
    fin_t        fin_tw;
    fin_t        fin_samp;
    state_t      st;

    assign d        = item.data_word;
    assign unit_fix = (d[31:24] == UNIT_ALIAS) ? UNIT_B : d[31:24];
    assign wc_bump  = (state_cur.words_counted != COUNT_MAX)
                      ? state_cur.words_counted + 17'd1 : state_cur.words_counted;
    assign cnt1_sum = {2'b00, d[31:24]} + {2'b00, d[23:16]}
                    + {2'b00, d[15:8]}  + {2'b00, d[7:0]};
    assign cnt2_sum = state_cur.clusters_left + {3'b000, d[31:24]};

    // Sample words: ceil(width * samples / 2), kept to 16 bits
    assign prod     = {8'd0, d[15:0]} * {16'd0, samples_per_channel};
    assign half_up  = prod[23:1] + {22'd0, prod[0]};
    assign swc      = half_up[15:0];
    assign samp_dec = (state_cur.samples_left != 16'd0)
                      ? state_cur.samples_left - 16'd1 : state_cur.samples_left;

    assign fin_tw   = finish_cluster(state_cur.clusters_left, wc_bump,
                                     state_cur.block_size);
    assign fin_samp = finish_cluster(state_cur.clusters_left, wc_bump,
                                     state_cur.block_size);

    always_comb
    begin
        st     = state_cur;
        result = '0;
        result.raw_word = d;

        // Fragment start abandons any block and clears the wide flag
        if (item.fragment_start)
        begin
            st.phase             = PH_HDR;
            st.wide_cluster_seen = 1'b0;
        end

        unique case (st.phase)
            PH_HDR:
            begin
                result.word_class = WC_HEADER;
                if (d == 32'd0)
                begin
                    if (st.null_header_total != NULL_TOTAL_MAX)
                        st.null_header_total = st.null_header_total + 16'd1;
                    st.current_unit  = 8'd0;
                    st.current_type  = 8'd0;
                    st.block_size    = 16'd0;
                    result.status    = ST_NULL;
                    result.block_end = 1'b1;
                end
                else
                begin
                    st.current_unit  = unit_fix;
                    st.current_type  = d[23:16];
                    st.block_size    = d[15:0];
                    st.words_counted = 17'd1;
                    if (d[23:16] == TYPE_EMPTY)
                        result.block_end = 1'b1;
                    else if (d[23:16] == TYPE_SKIP)
                    begin
                        if (d[15:0] > 16'd1)
                            st.phase = PH_SKIP;
                        else
                            result.block_end = 1'b1;
                    end
                    else if (d[15:0] == 16'd1)
                        result.block_end = 1'b1;
                    else
                        st.phase = PH_SCA;
                end
            end
            PH_SCA:
            begin
                result.word_class = WC_SAMP_ADDR;
                st.words_counted  = wc_bump;
                st.phase          = PH_CNT1;
            end
            PH_CNT1:
            begin
                result.word_class = WC_COUNTS;
                st.words_counted  = wc_bump;
                st.clusters_left  = {1'b0, cnt1_sum};
                if (st.current_unit != UNIT_A && st.current_unit != UNIT_B)
                    result.status = ST_UNKNOWN;
                st.phase = PH_CNT2;
            end
            PH_CNT2:
            begin
                result.word_class = WC_COUNT2;
                st.words_counted  = wc_bump;
                st.clusters_left  = cnt2_sum;
                if (cnt2_sum != 11'd0)
                    st.phase = PH_LOC;
                else if (wc_bump < {1'b0, st.block_size})
                    st.phase = PH_GHOST;
                else
                begin
                    result.block_end = 1'b1;
                    st.phase         = PH_HDR;
                end
            end
            PH_LOC:
            begin
                result.word_class = WC_LOCATION;
                st.words_counted  = wc_bump;
                st.phase          = PH_TW;
            end
            PH_TW:
            begin
                result.word_class        = WC_TIME_W;
                st.words_counted         = wc_bump;
                result.cluster_time      = d[27:16];
                result.cluster_width     = d[15:0];
                result.time_is_computed  = d[28];
                result.sample_word_count = swc;
                if (d[15:0] > WIDE_LIMIT)
                    st.wide_cluster_seen = 1'b1;
                st.samples_left = swc;
                if (swc != 16'd0)
                    st.phase = PH_SAMP;
                else
                begin
                    st.clusters_left = fin_tw.clusters;
                    st.phase         = fin_tw.phase;
                    result.status    = fin_tw.status;
                    result.block_end = fin_tw.end_flag;
                end
            end
            PH_SAMP:
            begin
                result.word_class = WC_SAMPLE;
                st.words_counted  = wc_bump;
                st.samples_left   = samp_dec;
                if (samp_dec == 16'd0)
                begin
                    st.clusters_left = fin_samp.clusters;
                    st.phase         = fin_samp.phase;
                    result.status    = fin_samp.status;
                    result.block_end = fin_samp.end_flag;
                end
            end
            PH_GHOST, PH_SKIP:
            begin
                result.word_class = (st.phase == PH_GHOST) ? WC_GHOST : WC_ERR_SKIP;
                st.words_counted  = wc_bump;
                if (wc_bump >= {1'b0, st.block_size})
                begin
                    result.block_end = 1'b1;
                    st.phase         = PH_HDR;
                end
            end
            default:
            begin
                result.word_class = WC_ERR_SKIP;
                st.phase          = PH_HDR;
            end
        endcase

        result.unit_id             = st.current_unit;
        result.block_type          = st.current_type;
        result.width_unrealistic   = st.wide_cluster_seen;
        result.missing_block_count = st.null_header_total;
        state_next                 = st;
    end

endmodule

/* rtl/readout_block_word_deframer.sv */
// Readout block word deframer: takes one 32-bit readout word per transfer and
// returns one classified result per word, in order. Each word is held in an
// input register, decoded against the block state, and written to a result
// register, so a word is accepted every cycle and its result is offered from
// the clock edge after the one that accepted it when the result side is not
// stalled. The throughput is set by the single block-state register, which is
// updated once per decoded word. samples_per_channel is written through
// cfg_write_en and cfg_write_data and resets to 4; write it only while the
// block is idle.
module readout_block_word_deframer
    import rbwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data
);

    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_next;
    state_t     state_reg;
    state_t     state_next;
    logic [7:0] samples_reg;
    logic       out_free;
    logic       fire;
    logic       accept;

    // Advance the word into the result register when the output slot frees
    assign out_free   = !out_valid_reg || result_ready;
    assign fire       = in_valid_reg && out_free;
    assign item_ready = !in_valid_reg || fire;
    assign accept     = item_valid && item_ready;

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    rbwd_decode u_decode (
        .item                (in_item_reg),
        .state_cur           (state_reg),
        .samples_per_channel (samples_reg),
        .state_next          (state_next),
        .result              (result_next)
    );

    // Hold control state, block state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            samples_reg   <= SAMPLES_RESET;
            state_reg     <= '{phase: PH_HDR, default: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                samples_reg <= cfg_write_data;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Capture payloads on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= item;
        if (fire)
            result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule
